// ===== src/vector_magnitude_stream_defines.svh =====
// vector_magnitude_stream_defines.svh: assertion macros for the magnitude stream checker
// no dependencies
`ifndef VECTOR_MAGNITUDE_STREAM_DEFINES_SVH
`define VECTOR_MAGNITUDE_STREAM_DEFINES_SVH

// checked only while out of reset
`define VMS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vms check failed");

// checked at every edge, reset included
`define VMS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vms check failed");

`endif

// ===== src/vms_pkg.sv =====
`timescale 1ns / 1ps
// vms_pkg: shared constants of the vector magnitude stream
// no dependencies
package vms_pkg;

    localparam int LENGTH_BITS = 4;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 4'd3;

    // control of the square stage
    typedef struct packed {
        logic valid;
        logic last;
    } vms_stage_ctrl_t;

endpackage

// ===== src/vms_interfaces.sv =====
`timescale 1ns / 1ps
// vms_interfaces: valid/ready channels of the vector magnitude stream
// depends on vms_pkg
interface vms_component_if #(
    parameter int WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] component;

    modport source (output valid, output component, input ready);
    modport sink (input valid, input component, output ready);
endinterface

interface vms_magnitude_if #(
    parameter int WIDTH = 25
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] magnitude;

    modport source (output valid, output magnitude, input ready);
    modport sink (input valid, input magnitude, output ready);
endinterface

interface vms_config_if;
    import vms_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LENGTH_BITS-1:0] vector_length;

    modport source (output valid, output vector_length, input ready);
    modport sink (input valid, input vector_length, output ready);
endinterface

// ===== src/vms_front.sv =====
`timescale 1ns / 1ps
// vms_front: length register, squaring and running sum of the components
// depends on vms_pkg and vms_interfaces
module vms_front #(
    parameter int COMPONENT_BITS    = 16,
    parameter int MAX_VECTOR_LENGTH = 8,
    parameter int SUM_BITS          = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    vms_component_if.sink         comp_ch,
    vms_config_if.sink            cfg_ch,
    input  logic                  advance,
    output logic                  rad_valid,
    output logic [SUM_BITS-1:0]   rad
);
    import vms_pkg::*;

    localparam int CNT_BITS = $clog2(MAX_VECTOR_LENGTH + 1);
    localparam int CMP_BITS = 6;
    localparam int SQ_BITS  = 2 * COMPONENT_BITS;

    logic [LENGTH_BITS-1:0]    length_reg;
    logic [CNT_BITS-1:0]       count_reg, count_next;
    vms_stage_ctrl_t           sq_ctrl_reg, sq_ctrl_next;
    logic [SQ_BITS-1:0]        sq_reg;
    logic [SUM_BITS-1:0]       sum_reg, sum_next;
    logic                      rad_valid_reg, rad_valid_next;
    logic [SUM_BITS-1:0]       rad_reg;
    logic [SUM_BITS-1:0]       total;
    logic [COMPONENT_BITS-1:0] abs_value;
    logic [CMP_BITS-1:0]       eff_len;
    logic [CMP_BITS-1:0]       len_wide;
    logic [CMP_BITS-1:0]       count_inc;
    logic                      accept;

    assign cfg_ch.ready  = 1'b1;
    assign comp_ch.ready = advance;
    assign accept        = comp_ch.valid && advance;

    // zero acts as one, too large clamps to the maximum
    always_comb
    begin
        len_wide = CMP_BITS'(length_reg);
        priority if (len_wide == '0)
            eff_len = CMP_BITS'(1);
        else if (len_wide > CMP_BITS'(MAX_VECTOR_LENGTH))
            eff_len = CMP_BITS'(MAX_VECTOR_LENGTH);
        else
            eff_len = len_wide;
    end

    always_comb
    begin
        abs_value = comp_ch.component[COMPONENT_BITS-1]
            ? (~comp_ch.component) + COMPONENT_BITS'(1)
            : comp_ch.component;
        count_inc = CMP_BITS'(count_reg) + CMP_BITS'(1);
        sq_ctrl_next.valid = accept;
        sq_ctrl_next.last  = count_inc >= eff_len;
        count_next = count_reg;
        if (accept)
            count_next = sq_ctrl_next.last ? '0 : CNT_BITS'(count_inc);
    end

    always_comb
    begin
        total          = sum_reg + SUM_BITS'(sq_reg);
        sum_next       = sum_reg;
        rad_valid_next = 1'b0;
        if (sq_ctrl_reg.valid)
        begin
            rad_valid_next = sq_ctrl_reg.last;
            sum_next       = sq_ctrl_reg.last ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= LENGTH_RESET;
            count_reg     <= '0;
            sq_ctrl_reg   <= '0;
            sum_reg       <= '0;
            rad_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
                length_reg <= cfg_ch.vector_length;
            if (advance)
            begin
                count_reg     <= count_next;
                sq_ctrl_reg   <= sq_ctrl_next;
                sum_reg       <= sum_next;
                rad_valid_reg <= rad_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg  <= abs_value * abs_value;
            rad_reg <= total;
        end
    end

    assign rad_valid = rad_valid_reg;
    assign rad       = rad_reg;

endmodule

// ===== src/vms_sqrt_cell.sv =====
`timescale 1ns / 1ps
// vms_sqrt_cell: one root bit of the square root chain
// no dependencies
module vms_sqrt_cell #(
    parameter int ROOT_BITS = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   valid_in,
    input  logic [2*ROOT_BITS-1:0] rad_in,
    input  logic [ROOT_BITS+1:0]   rem_in,
    input  logic [ROOT_BITS-1:0]   root_in,
    output logic                   valid_out,
    output logic [2*ROOT_BITS-1:0] rad_out,
    output logic [ROOT_BITS+1:0]   rem_out,
    output logic [ROOT_BITS-1:0]   root_out
);
    logic                   valid_reg;
    logic [2*ROOT_BITS-1:0] rad_reg, rad_next;
    logic [ROOT_BITS+1:0]   rem_reg, rem_next;
    logic [ROOT_BITS-1:0]   root_reg, root_next;
    logic [ROOT_BITS+1:0]   rem_shift;
    logic [ROOT_BITS+1:0]   trial;
    logic                   fits;

    always_comb
    begin
        rem_shift = {rem_in[ROOT_BITS-1:0], rad_in[2*ROOT_BITS-1 -: 2]};
        trial     = {root_in, 2'b01};
        fits      = rem_shift >= trial;
        rem_next  = fits ? rem_shift - trial : rem_shift;
        root_next = {root_in[ROOT_BITS-2:0], fits};
        rad_next  = {rad_in[2*ROOT_BITS-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

// ===== src/vector_magnitude_stream.sv =====
`timescale 1ns / 1ps
// vector_magnitude_stream: streaming Euclidean norm, top level
// depends on vms_pkg, vms_interfaces, vms_front and vms_sqrt_cell
//
// Usage:
//   comp_ch carries one signed component per request. After vector_length
//   components (0 acts as 1, values above MAX_VECTOR_LENGTH clamp) mag_ch
//   carries one request: floor(sqrt(sum of squares) * 2^FRACTION_BITS).
//   cfg_ch writes vector_length; it is always ready and is meant to be
//   written only while the block is empty. Reset sets the length to 3 and
//   clears the running sum and count.
//   From the last component of a vector to its magnitude the data passes
//   one squaring stage, one accumulator stage and one chain cell per root bit.
//   Throughput: one component per cycle; every stage advances together.
//   When the receiver holds mag_ch.ready low with a result waiting, the whole
//   pipeline freezes and comp_ch.ready drops until the result is taken.
module vector_magnitude_stream #(
    parameter int COMPONENT_BITS    = 16,
    parameter int MAX_VECTOR_LENGTH = 8,
    parameter int FRACTION_BITS     = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    vms_component_if.sink    comp_ch,
    vms_config_if.sink       cfg_ch,
    vms_magnitude_if.source  mag_ch
);
    import vms_pkg::*;

    localparam int SUM_BITS  = 2 * COMPONENT_BITS - 2 + $clog2(MAX_VECTOR_LENGTH + 1);
    localparam int ROOT_BITS = (SUM_BITS + 1) / 2 + FRACTION_BITS;
    localparam int RAD_BITS  = 2 * ROOT_BITS;

    logic                advance;
    logic                front_valid;
    logic [SUM_BITS-1:0] front_rad;

    logic                 valid_w [0:ROOT_BITS];
    logic [RAD_BITS-1:0]  rad_w   [0:ROOT_BITS];
    logic [ROOT_BITS+1:0] rem_w   [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_w  [0:ROOT_BITS];

    assign advance = !valid_w[ROOT_BITS] || mag_ch.ready;

    vms_front #(
        .COMPONENT_BITS    (COMPONENT_BITS),
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .SUM_BITS          (SUM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp_ch   (comp_ch),
        .cfg_ch    (cfg_ch),
        .advance   (advance),
        .rad_valid (front_valid),
        .rad       (front_rad)
    );

    // scale by 2^(2*FRACTION_BITS) before the root
    assign valid_w[0] = front_valid;
    assign rad_w[0]   = RAD_BITS'({front_rad, {(2 * FRACTION_BITS + 1){1'b0}}} >> 1);
    assign rem_w[0]   = '0;
    assign root_w[0]  = '0;

    for (genvar i = 0; i < ROOT_BITS; i++)
    begin : g_cell
        vms_sqrt_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_w[i]),
            .rad_in    (rad_w[i]),
            .rem_in    (rem_w[i]),
            .root_in   (root_w[i]),
            .valid_out (valid_w[i+1]),
            .rad_out   (rad_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .root_out  (root_w[i+1])
        );
    end

    assign mag_ch.valid     = valid_w[ROOT_BITS];
    assign mag_ch.magnitude = root_w[ROOT_BITS];

endmodule

// ===== src/vms_checker.sv =====
`timescale 1ns / 1ps
// vms_checker: port level checks of vector_magnitude_stream, bound to the top level
// depends on vector_magnitude_stream_defines.svh
`include "vector_magnitude_stream_defines.svh"

module vms_checker #(
    parameter int MAG_BITS = 25
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MAG_BITS-1:0] magnitude
);
    // a held result keeps its value
    `VMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(magnitude))

    // input side stalls exactly when a result is held back
    `VMS_ASSERT(a_backpressure, in_ready == (!out_valid || out_ready))

    // request valid is driven to a known level while out of reset
    `VMS_ASSERT(a_in_known, !$isunknown(in_valid))

    // nothing leaves straight after reset
    `VMS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind vector_magnitude_stream vms_checker #(
    .MAG_BITS ((2 * COMPONENT_BITS - 2 + $clog2(MAX_VECTOR_LENGTH + 1) + 1) / 2 + FRACTION_BITS)
) u_vms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (comp_ch.valid),
    .in_ready  (comp_ch.ready),
    .out_valid (mag_ch.valid),
    .out_ready (mag_ch.ready),
    .magnitude (mag_ch.magnitude)
);

// ===== test/vector_magnitude_stream_tb.sv =====
`timescale 1ns / 1ps
// vector_magnitude_stream_tb: self-checking bench for the streaming vector norm
// predicts each magnitude from the accepted components and compares it with the output
// depends on vms_pkg, vms_interfaces and vector_magnitude_stream
module vector_magnitude_stream_tb;
    import vms_pkg::*;

    localparam int COMPONENT_BITS    = 16;
    localparam int MAX_VECTOR_LENGTH = 8;
    localparam int FRACTION_BITS     = 8;
    localparam int MAGNITUDE_BITS    = 25;
    localparam int DRAIN_CYCLES      = 40;
    localparam int PHASE_ITEMS       = 55;

    typedef logic signed [COMPONENT_BITS-1:0] component_t;
    typedef logic [MAGNITUDE_BITS-1:0]        magnitude_t;

    // running sum of squares and the magnitudes it gives
    class norm_tracker;
        logic [LENGTH_BITS-1:0] length_reg;
        longint unsigned        square_sum;
        int                     taken;
        magnitude_t             expected_magnitudes[$];
        int                     failures;

        function new();
            length_reg = LENGTH_RESET;
            square_sum = 0;
            taken      = 0;
            failures   = 0;
        endfunction

        function void set_length(logic [LENGTH_BITS-1:0] value);
            length_reg = value;
        endfunction

        function int vector_span();
            if (length_reg == 0)
                return 1;
            if (length_reg > MAX_VECTOR_LENGTH)
                return MAX_VECTOR_LENGTH;
            return int'(length_reg);
        endfunction

        // floor of the square root, one bit at a time from the top
        function magnitude_t fixed_root(longint unsigned x);
            magnitude_t      root;
            longint unsigned trial;
            root = '0;
            for (int b = MAGNITUDE_BITS - 1; b >= 0; b--)
            begin
                trial = longint'(root) | (64'd1 << b);
                if (trial * trial <= x)
                    root[b] = 1'b1;
            end
            return root;
        endfunction

        function void take_component(component_t c);
            longint v;
            v = longint'(c);
            if (v < 0)
                v = -v;
            square_sum = square_sum + longint'(v * v);
            taken++;
            if (taken >= vector_span())
            begin
                expected_magnitudes.push_back(fixed_root(square_sum << (2 * FRACTION_BITS)));
                square_sum = 0;
                taken      = 0;
            end
        endfunction

        function void check_magnitude(magnitude_t m);
            magnitude_t want;
            if (expected_magnitudes.size() == 0)
            begin
                $error("magnitude: expected no request, got %0d", m);
                failures++;
                return;
            end
            want = expected_magnitudes.pop_front();
            if (m !== want)
            begin
                $error("magnitude: expected %0d, got %0d", want, m);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_magnitudes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    vms_component_if #(.WIDTH(COMPONENT_BITS)) comp_if ();
    vms_config_if                              cfg_if ();
    vms_magnitude_if #(.WIDTH(MAGNITUDE_BITS)) mag_if ();

    vector_magnitude_stream #(
        .COMPONENT_BITS    (COMPONENT_BITS),
        .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
        .FRACTION_BITS     (FRACTION_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .comp_ch (comp_if),
        .cfg_ch  (cfg_if),
        .mag_ch  (mag_if)
    );

    norm_tracker tracker = new();
    int          send_idle_pct;
    int          sink_stall_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("vector_magnitude_stream: mismatch");
        $finish;
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            mag_if.ready <= 1'b0;
            hold_cycles--;
        end
        else
            mag_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (comp_if.valid && comp_if.ready)
                tracker.take_component(comp_if.component);
            if (mag_if.valid && mag_if.ready)
                tracker.check_magnitude(mag_if.magnitude);
        end
    end

    task automatic send_component(input component_t c);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            comp_if.valid <= 1'b0;
            @(negedge clk);
        end
        comp_if.valid     <= 1'b1;
        comp_if.component <= c;
        @(posedge clk);
        while (!comp_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        comp_if.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // drain, let a partial vector settle, then write the length
    task automatic write_length(input logic [LENGTH_BITS-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.vector_length <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        tracker.set_length(value);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic component_t pick_component();
        unique case ($urandom_range(7))
            0: return component_t'(-32768);
            1: return component_t'(32767);
            2: return component_t'(int'($urandom_range(4)) - 2);
            default: return component_t'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [LENGTH_BITS-1:0] pick_length();
        if ($urandom_range(3) == 0)
            return LENGTH_BITS'($urandom_range(15));
        return LENGTH_BITS'($urandom_range(1, MAX_VECTOR_LENGTH));
    endfunction

    initial
    begin
        rst_n                = 1'b0;
        comp_if.valid        = 1'b0;
        comp_if.component    = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.vector_length = '0;
        mag_if.ready         = 1'b0;
        send_idle_pct        = 0;
        sink_stall_pct       = 0;
        hold_cycles          = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset length of three
        send_component(component_t'(-32768));
        send_component(component_t'(32767));
        send_component(component_t'(-32768));
        send_component(component_t'(0));
        send_component(component_t'(-1));
        send_component(component_t'(1));

        // longest vector of the most negative value
        write_length(LENGTH_BITS'(MAX_VECTOR_LENGTH));
        repeat (MAX_VECTOR_LENGTH) send_component(component_t'(-32768));

        // zero length acts as one
        write_length(LENGTH_BITS'(0));
        send_component(component_t'(32767));
        send_component(component_t'(-32768));

        // oversized length clamps, then shrinks mid-vector
        write_length(LENGTH_BITS'(15));
        send_component(component_t'(1));
        send_component(component_t'(-2));
        send_component(component_t'(3));
        write_length(LENGTH_BITS'(2));
        send_component(component_t'(-4));

        for (int phase = 0; phase < 8; phase++)
        begin
            write_length(pick_length());
            unique case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 19;
                    sink_stall_pct = 19;
                end
            endcase
            // long receiver hold-off so the pipeline backs up into the input
            if (phase == 0)
                hold_cycles = 300;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 5 && i == PHASE_ITEMS / 2)
                    wait_drained();
                send_component(pick_component());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.outstanding() == 0)
            $display("vector_magnitude_stream: match");
        else
            $display("vector_magnitude_stream: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/vms_pkg.sv
src/vms_interfaces.sv
src/vms_front.sv
src/vms_sqrt_cell.sv
src/vector_magnitude_stream.sv
src/vms_checker.sv
test/vector_magnitude_stream_tb.sv
